### sv/stl_pkg.sv
// Package: lexer states, token kinds, error codes and shared types.
package stl_pkg;

   localparam int VALUE_BITS_DEF = 31;
   localparam int MAX_RES = 3;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [4:0] {
      LX_START, LX_LT, LX_GT, LX_BANG, LX_EQ, LX_DIV, LX_LCOM, LX_BCOM, LX_BSTAR,
      LX_SOPEN, LX_SIN, LX_SESC, LX_SHEX1, LX_SHEX2, LX_SEMPTY,
      LX_MLIN, LX_MLQ1, LX_MLQ2,
      LX_ZERO, LX_INT, LX_HEX, LX_FDOT, LX_FDEC, LX_FE, LX_FESIGN, LX_FEXP
   } lex_state_type;

   typedef enum logic [4:0] {
      K_EOL, K_PLUS, K_MINUS, K_MULT, K_DIV, K_DOT, K_LT, K_LE, K_GT, K_GE,
      K_NE, K_EQ, K_ASSIGN, K_STREND, K_INT, K_DOUBLE, K_SBYTE, K_NBYTE, K_END
   } kind_type;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_BANG     = 3'd1;
   localparam logic [2:0] ERR_ESCAPE   = 3'd2;
   localparam logic [2:0] ERR_NUMBER   = 3'd3;
   localparam logic [2:0] ERR_UNTERM   = 3'd4;

   // one result slot as produced by the front end
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  value;
      logic [2:0]  err;
      logic        has_int;
   } slot_type;

   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= "0" && c <= "9") r = {1'b0, 4'(c - "0")};
      else if (c >= "a" && c <= "f") r = {1'b0, 4'(c - "a" + 8'd10)};
      else if (c >= "A" && c <= "F") r = {1'b0, 4'(c - "A" + 8'd10)};
      return r;
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

endpackage

### sv/stl_if.sv
// Valid/ready channel interfaces for requests and responses.
interface stl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;
   modport source (output valid, in_byte, end_of_input, input ready);
   modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

interface stl_rsp_if #(parameter int VALUE_BITS = 31);
   logic                  valid;
   logic                  ready;
   logic [4:0]            token_kind;
   logic [7:0]            byte_value;
   logic [VALUE_BITS-1:0] int_value;
   logic [2:0]            error_code;
   logic                  last;
   modport source (output valid, token_kind, byte_value, int_value, error_code, last,
                   input ready);
   modport sink (input valid, token_kind, byte_value, int_value, error_code, last,
                 output ready);
endinterface

### sv/stl_front.sv
// Front end: lexer state machine, integer accumulator, result slot generation.
module stl_front #(
   parameter int VALUE_BITS = stl_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            in_byte,
   input  logic                  end_of_input,
   output stl_pkg::slot_type     slots [stl_pkg::MAX_RES],
   output logic [1:0]            count,
   output logic [VALUE_BITS-1:0] int_val
);
   import stl_pkg::*;

   localparam logic [VALUE_BITS-1:0] MAXV = {VALUE_BITS{1'b1}};

   lex_state_type state_ff, state_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [3:0] nib_ff, nib_in;

   // fold the saturating accumulate: acc*base+d
   function automatic logic [VALUE_BITS-1:0] accum(input logic [VALUE_BITS-1:0] a,
                                                   input logic hex, input logic [3:0] d);
      logic [VALUE_BITS+4:0] p;
      p = hex ? ({5'd0, a} << 4) : (({5'd0, a} << 3) + ({5'd0, a} << 1));
      p = p + {{(VALUE_BITS+1){1'b0}}, d};
      return (p > {5'd0, MAXV}) ? MAXV : p[VALUE_BITS-1:0];
   endfunction

   always_comb begin
      slot_type s [MAX_RES];
      logic [1:0] n;
      logic [4:0] h;
      logic restart;
      lex_state_type st;
      logic [VALUE_BITS-1:0] acc;
      for (int i = 0; i < MAX_RES; i++) s[i] = '{K_END, 8'd0, ERR_NONE, 1'b0};
      n = 2'd0;
      restart = 1'b0;
      st = state_ff;
      acc = acc_ff;
      nib_in = nib_ff;
      int_val = acc_ff;
      h = hex_val(in_byte);
      if (end_of_input) begin
         case (state_ff)
            LX_LT: begin s[0].kind = K_LT; n = 2'd1; end
            LX_GT: begin s[0].kind = K_GT; n = 2'd1; end
            LX_EQ: begin s[0].kind = K_ASSIGN; n = 2'd1; end
            LX_DIV: begin s[0].kind = K_DIV; n = 2'd1; end
            LX_ZERO, LX_INT, LX_HEX: begin
               s[0].kind = K_INT; s[0].has_int = 1'b1; n = 2'd1;
            end
            LX_FDEC, LX_FEXP: begin s[0].kind = K_DOUBLE; n = 2'd1; end
            LX_SEMPTY: begin s[0].kind = K_STREND; n = 2'd1; end
            default: ;
         endcase
         s[n].kind = K_END;
         s[n].err = (state_ff inside {LX_LT, LX_GT, LX_EQ, LX_DIV, LX_ZERO, LX_INT,
            LX_HEX, LX_FDEC, LX_FEXP, LX_SEMPTY, LX_START, LX_LCOM}) ? ERR_NONE : ERR_UNTERM;
         n = n + 2'd1;
         st = LX_START; acc = '0; nib_in = 4'd0;
      end else begin
         case (state_ff)
            LX_LT: begin
               st = LX_START;
               if (in_byte == "=") begin s[0].kind = K_LE; n = 2'd1; end
               else begin s[0].kind = K_LT; n = 2'd1; restart = 1'b1; end
            end
            LX_GT: begin
               st = LX_START;
               if (in_byte == "=") begin s[0].kind = K_GE; n = 2'd1; end
               else begin s[0].kind = K_GT; n = 2'd1; restart = 1'b1; end
            end
            LX_EQ: begin
               st = LX_START;
               if (in_byte == "=") begin s[0].kind = K_EQ; n = 2'd1; end
               else begin s[0].kind = K_ASSIGN; n = 2'd1; restart = 1'b1; end
            end
            LX_BANG: begin
               st = LX_START;
               if (in_byte == "=") begin s[0].kind = K_NE; n = 2'd1; end
               else begin
                  s[0].err = ERR_BANG; n = 2'd1; acc = '0; nib_in = 4'd0;
               end
            end
            LX_DIV: begin
               if (in_byte == "*") st = LX_BCOM;
               else if (in_byte == "/") st = LX_LCOM;
               else begin
                  st = LX_START; s[0].kind = K_DIV; n = 2'd1; restart = 1'b1;
               end
            end
            LX_LCOM: if (in_byte == 8'h0a) st = LX_START;
            LX_BCOM: if (in_byte == "*") st = LX_BSTAR;
            LX_BSTAR: begin
               if (in_byte == "/") st = LX_START;
               else if (in_byte != "*") st = LX_BCOM;
            end
            LX_SOPEN, LX_SIN: begin
               if (in_byte == "\"") begin
                  if (state_ff == LX_SOPEN) st = LX_SEMPTY;
                  else begin st = LX_START; s[0].kind = K_STREND; n = 2'd1; end
               end else if (in_byte == "\\") st = LX_SESC;
               else begin
                  s[0].kind = K_SBYTE; s[0].value = in_byte; n = 2'd1; st = LX_SIN;
               end
            end
            LX_SESC: begin
               st = LX_SIN;
               s[0].kind = K_SBYTE; n = 2'd1;
               case (in_byte)
                  "x": begin st = LX_SHEX1; n = 2'd0; end
                  "\"": s[0].value = "\"";
                  "r": s[0].value = 8'h0d;
                  "n": s[0].value = 8'h0a;
                  "t": s[0].value = 8'h09;
                  "\\": s[0].value = "\\";
                  default: begin
                     s[0].kind = K_END; s[0].err = ERR_ESCAPE; st = LX_START;
                     acc = '0; nib_in = 4'd0;
                  end
               endcase
            end
            LX_SHEX1: begin
               if (h[4]) begin
                  s[0].err = ERR_ESCAPE; n = 2'd1; st = LX_START; acc = '0; nib_in = 4'd0;
               end else begin nib_in = h[3:0]; st = LX_SHEX2; end
            end
            LX_SHEX2: begin
               n = 2'd1; nib_in = 4'd0;
               if (h[4]) begin
                  s[0].err = ERR_ESCAPE; st = LX_START; acc = '0;
               end else begin
                  s[0].kind = K_SBYTE; s[0].value = {nib_ff, h[3:0]}; st = LX_SIN;
               end
            end
            LX_SEMPTY: begin
               if (in_byte == "\"") st = LX_MLIN;
               else begin
                  st = LX_START; s[0].kind = K_STREND; n = 2'd1; restart = 1'b1;
               end
            end
            LX_MLIN: begin
               if (in_byte == "\"") st = LX_MLQ1;
               else begin s[0].kind = K_SBYTE; s[0].value = in_byte; n = 2'd1; end
            end
            LX_MLQ1: begin
               if (in_byte == "\"") st = LX_MLQ2;
               else begin
                  s[0] = '{K_SBYTE, "\"", ERR_NONE, 1'b0};
                  s[1] = '{K_SBYTE, in_byte, ERR_NONE, 1'b0};
                  n = 2'd2; st = LX_MLIN;
               end
            end
            LX_MLQ2: begin
               if (in_byte == "\"") begin st = LX_START; s[0].kind = K_STREND; n = 2'd1; end
               else begin
                  s[0] = '{K_SBYTE, "\"", ERR_NONE, 1'b0};
                  s[1] = '{K_SBYTE, "\"", ERR_NONE, 1'b0};
                  s[2] = '{K_SBYTE, in_byte, ERR_NONE, 1'b0};
                  n = 2'd3; st = LX_MLIN;
               end
            end
            LX_ZERO, LX_INT: begin
               s[0] = '{K_NBYTE, in_byte, ERR_NONE, 1'b0}; n = 2'd1;
               if (state_ff == LX_ZERO && in_byte == "x") st = LX_HEX;
               else if (in_byte == "e" || in_byte == "E") begin
                  s[0].value = "e"; st = LX_FE;
               end else if (in_byte == ".") st = LX_FDOT;
               else if (is_dig(in_byte)) begin
                  acc = accum(acc_ff, 1'b0, h[3:0]); st = LX_INT;
               end else begin
                  s[0] = '{K_INT, 8'd0, ERR_NONE, 1'b1};
                  acc = '0; st = LX_START; restart = 1'b1;
               end
            end
            LX_HEX: begin
               n = 2'd1;
               if (!h[4]) begin
                  s[0] = '{K_NBYTE, in_byte, ERR_NONE, 1'b0};
                  acc = accum(acc_ff, 1'b1, h[3:0]);
               end else begin
                  s[0] = '{K_INT, 8'd0, ERR_NONE, 1'b1};
                  acc = '0; st = LX_START; restart = 1'b1;
               end
            end
            LX_FDOT, LX_FESIGN: begin
               n = 2'd1;
               if (!is_dig(in_byte)) begin
                  s[0].err = ERR_NUMBER; st = LX_START; acc = '0; nib_in = 4'd0;
               end else begin
                  s[0] = '{K_NBYTE, in_byte, ERR_NONE, 1'b0};
                  st = (state_ff == LX_FDOT) ? LX_FDEC : LX_FEXP;
               end
            end
            LX_FE: begin
               n = 2'd1;
               if (in_byte == "+" || in_byte == "-") begin
                  s[0] = '{K_NBYTE, in_byte, ERR_NONE, 1'b0}; st = LX_FESIGN;
               end else if (is_dig(in_byte)) begin
                  s[0] = '{K_NBYTE, in_byte, ERR_NONE, 1'b0}; st = LX_FEXP;
               end else begin
                  s[0].err = ERR_NUMBER; st = LX_START; acc = '0; nib_in = 4'd0;
               end
            end
            LX_FDEC, LX_FEXP: begin
               n = 2'd1;
               if (state_ff == LX_FDEC && (in_byte == "e" || in_byte == "E")) begin
                  s[0] = '{K_NBYTE, "e", ERR_NONE, 1'b0}; st = LX_FE;
               end else if (is_dig(in_byte)) begin
                  s[0] = '{K_NBYTE, in_byte, ERR_NONE, 1'b0};
               end else begin
                  s[0].kind = K_DOUBLE; st = LX_START; acc = '0; restart = 1'b1;
               end
            end
            default: begin st = LX_START; restart = 1'b1; end
         endcase
         if (restart) begin
            case (in_byte)
               8'h0a: begin s[n].kind = K_EOL; n = n + 2'd1; end
               "+": begin s[n].kind = K_PLUS; n = n + 2'd1; end
               "-": begin s[n].kind = K_MINUS; n = n + 2'd1; end
               "*": begin s[n].kind = K_MULT; n = n + 2'd1; end
               ".": begin s[n].kind = K_DOT; n = n + 2'd1; end
               "/": st = LX_DIV;
               ">": st = LX_GT;
               "<": st = LX_LT;
               "!": st = LX_BANG;
               "=": st = LX_EQ;
               "\"": st = LX_SOPEN;
               default: begin
                  if (is_dig(in_byte)) begin
                     acc = {{(VALUE_BITS-4){1'b0}}, h[3:0]};
                     s[n] = '{K_NBYTE, in_byte, ERR_NONE, 1'b0}; n = n + 2'd1;
                     st = (in_byte == "0") ? LX_ZERO : LX_INT;
                  end
               end
            endcase
         end
      end
      slots = s;
      count = n;
      state_in = st;
      acc_in = acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LX_START;
         acc_ff <= '0;
         nib_ff <= 4'd0;
      end else if (step) begin
         state_ff <= state_in;
         acc_ff <= acc_in;
         nib_ff <= nib_in;
      end
   end
endmodule

### sv/stl_queue.sv
// Queue of result bundles between front end and back end.
module stl_queue #(
   parameter int VALUE_BITS = stl_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  stl_pkg::slot_type     push_slots [stl_pkg::MAX_RES],
   input  logic [1:0]            push_count,
   input  logic [VALUE_BITS-1:0] push_int,
   output logic                  full,
   output logic                  empty,
   input  logic                  pop,
   output stl_pkg::slot_type     head_slots [stl_pkg::MAX_RES],
   output logic [1:0]            head_count,
   output logic [VALUE_BITS-1:0] head_int
);
   import stl_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);

   slot_type              slots_ff [QUEUE_DEPTH][MAX_RES];
   logic [1:0]            cnt_ff [QUEUE_DEPTH];
   logic [VALUE_BITS-1:0] int_ff [QUEUE_DEPTH];
   logic [AW-1:0]         wr_ff, rd_ff;
   logic [AW:0]           fill_ff;

   assign full = fill_ff == (AW+1)'(QUEUE_DEPTH);
   assign empty = fill_ff == '0;
   assign head_slots = slots_ff[rd_ff];
   assign head_count = cnt_ff[rd_ff];
   assign head_int = int_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_slots;
         cnt_ff[wr_ff] <= push_count;
         int_ff[wr_ff] <= push_int;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         fill_ff <= fill_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end
endmodule

### sv/stl_back.sv
// Back end: walks the slots of each bundle out on the response channel.
module stl_back #(
   parameter int VALUE_BITS = stl_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  empty,
   input  stl_pkg::slot_type     head_slots [stl_pkg::MAX_RES],
   input  logic [1:0]            head_count,
   input  logic [VALUE_BITS-1:0] head_int,
   output logic                  pop,
   stl_rsp_if.source             rsp
);
   import stl_pkg::*;

   logic [1:0] idx_ff, idx_in;
   slot_type   cur;
   logic       fire, is_last;

   assign cur = head_slots[idx_ff];
   assign is_last = idx_ff + 2'd1 == head_count;
   assign rsp.valid = !empty;
   assign rsp.token_kind = cur.kind;
   assign rsp.byte_value = cur.value;
   assign rsp.int_value = cur.has_int ? head_int : '0;
   assign rsp.error_code = cur.err;
   assign rsp.last = is_last;
   assign fire = rsp.valid && rsp.ready;
   assign pop = fire && is_last;
   assign idx_in = pop ? 2'd0 : (fire ? idx_ff + 2'd1 : idx_ff);

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 2'd0;
      else idx_ff <= idx_in;
   end
endmodule

### sv/source_token_lexer_core.sv
// Top level of the byte-serial source token lexer.
//   channel | dir | payload
//   req     | in  | in_byte, end_of_input
//   rsp     | out | token_kind, byte_value, int_value, error_code, last
// One request is taken per cycle while the result queue has room; each
// request updates the front state machine and accumulator registers.
// Each request yields zero to three responses, one per cycle while rsp.ready is high.
// Reset (synchronous) empties the queue and returns to the start state.
// A stall on rsp fills the four-entry queue, then holds req.ready low.
module source_token_lexer_core #(
   parameter int VALUE_BITS = stl_pkg::VALUE_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   stl_req_if.sink   req,
   stl_rsp_if.source rsp
);
   import stl_pkg::*;

   slot_type              f_slots [MAX_RES];
   slot_type              h_slots [MAX_RES];
   logic [1:0]            f_count, h_count;
   logic [VALUE_BITS-1:0] f_int, h_int;
   logic                  full, empty, pop, step;

   assign req.ready = !full;
   assign step = req.valid && !full;

   stl_front #(.VALUE_BITS(VALUE_BITS)) u_front (
      .clock, .reset, .step, .in_byte(req.in_byte), .end_of_input(req.end_of_input),
      .slots(f_slots), .count(f_count), .int_val(f_int)
   );

   stl_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
      .clock, .reset, .push(step && f_count != 2'd0), .push_slots(f_slots),
      .push_count(f_count), .push_int(f_int), .full, .empty, .pop,
      .head_slots(h_slots), .head_count(h_count), .head_int(h_int)
   );

   stl_back #(.VALUE_BITS(VALUE_BITS)) u_back (
      .clock, .reset, .empty, .head_slots(h_slots), .head_count(h_count),
      .head_int(h_int), .pop, .rsp
   );
endmodule

### verif/source_token_lexer_core_checker.sv
// Checker for the source token lexer: predicts each request's tokens and compares responses.
module source_token_lexer_core_checker
   import stl_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_in_byte,
   input logic        req_end_of_input,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_token_kind,
   input logic [7:0]  rsp_byte_value,
   input logic [30:0] rsp_int_value,
   input logic [2:0]  rsp_error_code,
   input logic        rsp_last,
   output int         fail_count,
   output int         tokens_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [4:0]  kind;
      logic [7:0]  value;
      logic [30:0] ival;
      logic [2:0]  err;
      logic        last;
   } token_type;

   localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;

   token_type     token_queue[$];
   token_type     step_tokens[$];
   lex_state_type lex;
   logic [30:0]   acc;
   logic [3:0]    high_nib;

   assign tokens_pending = token_queue.size();

   function automatic int digit_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic bit is_decimal(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   task automatic push_token(input kind_type k, input logic [7:0] v,
                             input logic [30:0] iv, input logic [2:0] e);
      token_type t;
      t.kind = k;
      t.value = v;
      t.ival = iv;
      t.err = e;
      t.last = 1'b0;
      if (step_tokens.size() < MAX_RES) step_tokens.push_back(t);
   endtask

   task automatic add_digit(input int base, input int d);
      longint unsigned nxt;
      nxt = longint'(acc) * base + d;
      acc = (nxt > INT_MAX) ? INT_MAX : nxt[30:0];
   endtask

   task automatic lex_error(input logic [2:0] e);
      push_token(K_END, 0, 0, e);
      lex = LX_START;
      acc = 0;
      high_nib = 0;
   endtask

   task automatic start_char(input logic [7:0] c);
      case (c)
         "\n": push_token(K_EOL, 0, 0, ERR_NONE);
         "+": push_token(K_PLUS, 0, 0, ERR_NONE);
         "-": push_token(K_MINUS, 0, 0, ERR_NONE);
         "*": push_token(K_MULT, 0, 0, ERR_NONE);
         ".": push_token(K_DOT, 0, 0, ERR_NONE);
         "/": lex = LX_DIV;
         ">": lex = LX_GT;
         "<": lex = LX_LT;
         "!": lex = LX_BANG;
         "=": lex = LX_EQ;
         "\"": lex = LX_SOPEN;
         default: begin
            if (is_decimal(c)) begin
               acc = 31'(c - "0");
               push_token(K_NBYTE, c, 0, ERR_NONE);
               lex = (c == "0") ? LX_ZERO : LX_INT;
            end
         end
      endcase
   endtask

   task automatic end_number();
      push_token(K_INT, 0, acc, ERR_NONE);
      acc = 0;
      lex = LX_START;
   endtask

   task automatic lex_char(input logic [7:0] c);
      int h;
      case (lex)
         LX_LT, LX_GT, LX_EQ: begin
            lex_state_type s;
            s = lex;
            lex = LX_START;
            if (c == "=")
               push_token(s == LX_LT ? K_LE : s == LX_GT ? K_GE : K_EQ, 0, 0, ERR_NONE);
            else begin
               push_token(s == LX_LT ? K_LT : s == LX_GT ? K_GT : K_ASSIGN, 0, 0, ERR_NONE);
               start_char(c);
            end
         end
         LX_BANG: begin
            if (c == "=") begin
               lex = LX_START;
               push_token(K_NE, 0, 0, ERR_NONE);
            end else lex_error(ERR_BANG);
         end
         LX_DIV: begin
            if (c == "*") lex = LX_BCOM;
            else if (c == "/") lex = LX_LCOM;
            else begin
               lex = LX_START;
               push_token(K_DIV, 0, 0, ERR_NONE);
               start_char(c);
            end
         end
         LX_LCOM: if (c == "\n") lex = LX_START;
         LX_BCOM: if (c == "*") lex = LX_BSTAR;
         LX_BSTAR: begin
            if (c == "/") lex = LX_START;
            else if (c != "*") lex = LX_BCOM;
         end
         LX_SOPEN, LX_SIN: begin
            if (c == "\"") begin
               if (lex == LX_SOPEN) lex = LX_SEMPTY;
               else begin
                  lex = LX_START;
                  push_token(K_STREND, 0, 0, ERR_NONE);
               end
            end else if (c == "\\") lex = LX_SESC;
            else begin
               push_token(K_SBYTE, c, 0, ERR_NONE);
               lex = LX_SIN;
            end
         end
         LX_SESC: begin
            lex = LX_SIN;
            case (c)
               "x": lex = LX_SHEX1;
               "\"": push_token(K_SBYTE, "\"", 0, ERR_NONE);
               "r": push_token(K_SBYTE, 8'h0D, 0, ERR_NONE);
               "n": push_token(K_SBYTE, 8'h0A, 0, ERR_NONE);
               "t": push_token(K_SBYTE, 8'h09, 0, ERR_NONE);
               "\\": push_token(K_SBYTE, "\\", 0, ERR_NONE);
               default: lex_error(ERR_ESCAPE);
            endcase
         end
         LX_SHEX1: begin
            h = digit_of(c);
            if (h < 0) lex_error(ERR_ESCAPE);
            else begin
               high_nib = h[3:0];
               lex = LX_SHEX2;
            end
         end
         LX_SHEX2: begin
            h = digit_of(c);
            if (h < 0) lex_error(ERR_ESCAPE);
            else begin
               push_token(K_SBYTE, {high_nib, h[3:0]}, 0, ERR_NONE);
               high_nib = 0;
               lex = LX_SIN;
            end
         end
         LX_SEMPTY: begin
            if (c == "\"") lex = LX_MLIN;
            else begin
               lex = LX_START;
               push_token(K_STREND, 0, 0, ERR_NONE);
               start_char(c);
            end
         end
         LX_MLIN: begin
            if (c == "\"") lex = LX_MLQ1;
            else push_token(K_SBYTE, c, 0, ERR_NONE);
         end
         LX_MLQ1: begin
            if (c == "\"") lex = LX_MLQ2;
            else begin
               push_token(K_SBYTE, "\"", 0, ERR_NONE);
               push_token(K_SBYTE, c, 0, ERR_NONE);
               lex = LX_MLIN;
            end
         end
         LX_MLQ2: begin
            if (c == "\"") begin
               lex = LX_START;
               push_token(K_STREND, 0, 0, ERR_NONE);
            end else begin
               push_token(K_SBYTE, "\"", 0, ERR_NONE);
               push_token(K_SBYTE, "\"", 0, ERR_NONE);
               push_token(K_SBYTE, c, 0, ERR_NONE);
               lex = LX_MLIN;
            end
         end
         LX_ZERO, LX_INT: begin
            if (lex == LX_ZERO && c == "x") begin
               push_token(K_NBYTE, c, 0, ERR_NONE);
               lex = LX_HEX;
            end else if (c == "e" || c == "E") begin
               push_token(K_NBYTE, "e", 0, ERR_NONE);
               lex = LX_FE;
            end else if (c == ".") begin
               push_token(K_NBYTE, c, 0, ERR_NONE);
               lex = LX_FDOT;
            end else if (is_decimal(c)) begin
               add_digit(10, int'(c - "0"));
               push_token(K_NBYTE, c, 0, ERR_NONE);
               lex = LX_INT;
            end else begin
               end_number();
               start_char(c);
            end
         end
         LX_HEX: begin
            h = digit_of(c);
            if (h >= 0) begin
               add_digit(16, h);
               push_token(K_NBYTE, c, 0, ERR_NONE);
            end else begin
               end_number();
               start_char(c);
            end
         end
         LX_FDOT, LX_FESIGN: begin
            if (!is_decimal(c)) lex_error(ERR_NUMBER);
            else begin
               push_token(K_NBYTE, c, 0, ERR_NONE);
               lex = (lex == LX_FDOT) ? LX_FDEC : LX_FEXP;
            end
         end
         LX_FE: begin
            if (c == "+" || c == "-") begin
               push_token(K_NBYTE, c, 0, ERR_NONE);
               lex = LX_FESIGN;
            end else if (is_decimal(c)) begin
               push_token(K_NBYTE, c, 0, ERR_NONE);
               lex = LX_FEXP;
            end else lex_error(ERR_NUMBER);
         end
         LX_FDEC, LX_FEXP: begin
            if (lex == LX_FDEC && (c == "e" || c == "E")) begin
               push_token(K_NBYTE, "e", 0, ERR_NONE);
               lex = LX_FE;
            end else if (is_decimal(c)) push_token(K_NBYTE, c, 0, ERR_NONE);
            else begin
               lex = LX_START;
               acc = 0;
               push_token(K_DOUBLE, 0, 0, ERR_NONE);
               start_char(c);
            end
         end
         default: begin
            lex = LX_START;
            start_char(c);
         end
      endcase
   endtask

   task automatic lex_finish();
      logic [2:0] e;
      e = ERR_NONE;
      case (lex)
         LX_LT: push_token(K_LT, 0, 0, ERR_NONE);
         LX_GT: push_token(K_GT, 0, 0, ERR_NONE);
         LX_EQ: push_token(K_ASSIGN, 0, 0, ERR_NONE);
         LX_DIV: push_token(K_DIV, 0, 0, ERR_NONE);
         LX_ZERO, LX_INT, LX_HEX: push_token(K_INT, 0, acc, ERR_NONE);
         LX_FDEC, LX_FEXP: push_token(K_DOUBLE, 0, 0, ERR_NONE);
         LX_SEMPTY: push_token(K_STREND, 0, 0, ERR_NONE);
         LX_START, LX_LCOM: ;
         default: e = ERR_UNTERM;
      endcase
      push_token(K_END, 0, 0, e);
      lex = LX_START;
      acc = 0;
      high_nib = 0;
   endtask

   always @(posedge clock) begin
      token_type got, want;
      if (reset) begin
         lex = LX_START;
         acc = 0;
         high_nib = 0;
         token_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_token_kind, rsp_byte_value, rsp_int_value, rsp_error_code, rsp_last};
            if (token_queue.size() == 0) begin
               $display("%0t: unexpected response %h", $realtime, got);
               fail_count++;
            end else begin
               want = token_queue.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected kind %0d byte %h int %0d err %0d last %b",
                           $realtime, want.kind, want.value, want.ival, want.err, want.last);
                  $display("%0t:          actual kind %0d byte %h int %0d err %0d last %b",
                           $realtime, got.kind, got.value, got.ival, got.err, got.last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            step_tokens.delete();
            if (req_end_of_input) lex_finish();
            else lex_char(req_in_byte);
            if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
            foreach (step_tokens[i]) token_queue.push_back(step_tokens[i]);
         end
      end
   end
endmodule

### verif/source_token_lexer_core_test.sv
// Testbench top for the source token lexer: stimulus, stalls and verdict.
module source_token_lexer_core_test;
   import stl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   tokens_pending;
   bit   hold_off = 1'b0;
   bit   requests_done = 1'b0;
   byte  unsigned src_bytes[$];
   bit   src_marks[$];

   stl_req_if req ();
   stl_rsp_if #(.VALUE_BITS(31)) rsp ();

   source_token_lexer_core #(.VALUE_BITS(31)) dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp)
   );

   source_token_lexer_core_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .req_in_byte(req.in_byte), .req_end_of_input(req.end_of_input),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_token_kind(rsp.token_kind), .rsp_byte_value(rsp.byte_value),
      .rsp_int_value(rsp.int_value), .rsp_error_code(rsp.error_code),
      .rsp_last(rsp.last), .fail_count(fail_count), .tokens_pending(tokens_pending)
   );

   always #4 clock = ~clock;

   initial begin
      #2ms;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic add_text(input string s);
      foreach (s[i]) begin
         src_bytes.push_back(s[i]);
         src_marks.push_back(1'b0);
      end
   endtask

   task automatic add_end();
      src_bytes.push_back($urandom_range(0, 255));
      src_marks.push_back(1'b1);
   endtask

   function automatic string random_fragment();
      string pool[24];
      string s;
      pool = '{"a<=b", "x>=1", "!=", "==", "=3", "< >", "+-*.", "/ 2", "// note\n",
               "/* c ** x */", "\"ab\\n\\t\\\\\\\"\\r\"", "\"\\x4Fz\\xa0\"", "\"\"",
               "\"\"\"m\"i\"\"x\n\"\"\"", "0x1F ", "0xFFFFFFFFF ", "99999999999 ",
               "3.25 ", "1e+5 ", "2.5E-3;", "7e9\n", "0x", "12.", "\"\\q\""};
      s = pool[$urandom_range(0, 23)];
      if ($urandom_range(0, 3) == 0) s = {s, string'(byte'($urandom_range(1, 255)))};
      return s;
   endfunction

   initial begin
      int n;
      int gap;
      req.valid = 1'b0;
      req.in_byte = 8'h00;
      req.end_of_input = 1'b0;
      add_text("a<b<=c>d>=e!=f==g=h+i-j*k/l.m\n");
      add_end();
      add_text("\"s\\x41\\xZ"); add_text("!x1.x2e+y0x"); add_end();
      add_text("\"abc"); add_end();
      add_text("/* x"); add_end();
      add_text("2147483648 0xfF 1.5e9"); add_end();
      while (src_bytes.size() < 262) begin
         n = $urandom_range(0, 9);
         if (n == 0) add_end();
         else if (n == 1) begin
            src_bytes.push_back($urandom_range(0, 255));
            src_marks.push_back(1'b0);
         end else add_text(random_fragment());
      end
      src_bytes.push_back(8'hFF); src_marks.push_back(1'b0);
      add_end();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (src_bytes[i]) begin
         gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
         repeat (gap) @(negedge clock);
         req.valid = 1'b1;
         req.in_byte = src_bytes[i];
         req.end_of_input = src_marks[i];
         @(posedge clock);
         while (!req.ready) @(posedge clock);
         @(negedge clock);
         req.valid = 1'b0;
      end
      requests_done = 1'b1;
      while (tokens_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      rsp.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      repeat (40) @(negedge clock);
      hold_off = 1'b1;
      repeat (60) @(negedge clock);
      hold_off = 1'b0;
   end

   initial begin
      int wait_cycles;
      @(negedge clock);
      forever begin
         wait_cycles = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
         if (hold_off || wait_cycles != 0) begin
            rsp.ready = 1'b0;
            repeat (wait_cycles > 0 ? wait_cycles : 1) @(negedge clock);
         end else begin
            rsp.ready = 1'b1;
            @(posedge clock);
            while (!rsp.valid) @(posedge clock);
            @(negedge clock);
         end
      end
   end
endmodule

### filelist.f
sv/stl_pkg.sv
sv/stl_if.sv
sv/stl_front.sv
sv/stl_queue.sv
sv/stl_back.sv
sv/source_token_lexer_core.sv
verif/source_token_lexer_core_checker.sv
verif/source_token_lexer_core_test.sv
